// ----- rtl/lkrc_pkg.sv -----
// shared types and constants for the keyed record cache
package lkrc_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned PayloadWidthDefault = 64;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned CapWidth = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    MODE_GET   = 2'd0,
    MODE_PUT   = 2'd1,
    MODE_ERASE = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_EXEC,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic evict;    // remove least recent entry
    logic exec;     // perform the operation
  } lkrc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_evict;
  } lkrc_sts_t;

endpackage

// ----- rtl/lkrc_datapath.sv -----
// entry store, key compare, rank update and result register
module lkrc_datapath #(
  parameter int unsigned Entries = lkrc_pkg::EntriesDefault,
  parameter int unsigned PayloadWidth = lkrc_pkg::PayloadWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lkrc_pkg::lkrc_cmd_t          cmd_i,
  output lkrc_pkg::lkrc_sts_t          sts_o,
  input  logic [lkrc_pkg::CapWidth-1:0] cap_i,
  input  logic [1:0]                   mode_i,
  input  logic [31:0]                  key_i,
  input  logic [63:0]                  entry_data_i,
  output logic                         hit_o,
  output logic [63:0]                  read_data_o
);
  import lkrc_pkg::*;

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  logic [Entries-1:0]      valid_q, valid_d;
  logic [KeyWidth-1:0]     key_mem_q [Entries];
  logic [PayloadWidth-1:0] pay_q [Entries];
  logic [IdxW-1:0]         rank_q [Entries];
  logic [IdxW-1:0]         rank_d [Entries];
  logic [CntW-1:0]         count_q, count_d;

  logic [1:0]              req_mode_q;
  logic [KeyWidth-1:0]     req_key_q;
  logic [PayloadWidth-1:0] req_data_q;

  logic                    hit_q, hit_d;
  logic [63:0]             rdata_q;
  logic                    rd_en;

  // match and helpers
  logic [Entries-1:0] match;
  logic               found;
  logic [IdxW-1:0]    found_idx;
  logic [IdxW-1:0]    victim_idx;
  logic [IdxW-1:0]    free_idx;
  logic               free_ok;
  logic [CntW-1:0]    cap_sat;
  logic [IdxW-1:0]    ref_rank;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;

  always_comb begin
    found = 1'b0;
    found_idx = '0;
    victim_idx = '0;
    free_ok = 1'b0;
    free_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      match[i] = valid_q[i] && (key_mem_q[i] == req_key_q);
      if (match[i] && !found) begin
        found = 1'b1;
        found_idx = IdxW'(i);
      end
      // least recent has the highest rank, count-1
      if (valid_q[i] && (CntW'(rank_q[i]) == CntW'(count_q - 1'b1))) begin
        victim_idx = IdxW'(i);
      end
      if (!valid_q[i] && !free_ok) begin
        free_ok = 1'b1;
        free_idx = IdxW'(i);
      end
    end
    if (32'(cap_i) > Entries) cap_sat = CntW'(Entries);
    else cap_sat = CntW'(cap_i);
  end

  assign sts_o.need_evict = (req_mode_q == MODE_PUT) && (cap_sat != '0) && !found
                            && (count_q >= cap_sat) && (count_q != '0);

  // state update
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    hit_d = hit_q;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_idx = free_idx;
    ref_rank = rank_q[found_idx];
    for (int i = 0; i < Entries; i++) rank_d[i] = rank_q[i];
    if (cmd_i.evict) begin
      ref_rank = rank_q[victim_idx];
      valid_d[victim_idx] = 1'b0;
      rank_d[victim_idx] = '0;
      for (int i = 0; i < Entries; i++)
        if (valid_q[i] && rank_q[i] > ref_rank) rank_d[i] = rank_q[i] - 1'b1;
      count_d = count_q - 1'b1;
    end else if (cmd_i.exec) begin
      hit_d = 1'b0;
      unique case (mode_e'(req_mode_q))
        MODE_GET: begin
          if (found) begin
            hit_d = 1'b1;
            rd_en = 1'b1;
            for (int i = 0; i < Entries; i++)
              if (valid_q[i] && rank_q[i] < ref_rank) rank_d[i] = rank_q[i] + 1'b1;
            rank_d[found_idx] = '0;
          end
        end
        MODE_PUT: begin
          if (cap_sat != '0) begin
            if (found) begin
              hit_d = 1'b1;
              wr_en = 1'b1;
              wr_idx = found_idx;
              for (int i = 0; i < Entries; i++)
                if (valid_q[i] && rank_q[i] < ref_rank) rank_d[i] = rank_q[i] + 1'b1;
              rank_d[found_idx] = '0;
            end else if (free_ok) begin
              wr_en = 1'b1;
              for (int i = 0; i < Entries; i++)
                if (valid_q[i]) rank_d[i] = rank_q[i] + 1'b1;
              rank_d[free_idx] = '0;
              valid_d[free_idx] = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
        end
        MODE_ERASE: begin
          if (found) begin
            hit_d = 1'b1;
            valid_d[found_idx] = 1'b0;
            rank_d[found_idx] = '0;
            for (int i = 0; i < Entries; i++)
              if (valid_q[i] && rank_q[i] > ref_rank) rank_d[i] = rank_q[i] - 1'b1;
            count_d = count_q - 1'b1;
          end
        end
        MODE_CLEAR: begin
          valid_d = '0;
          for (int i = 0; i < Entries; i++) rank_d[i] = '0;
          count_d = '0;
        end
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < Entries; i++) rank_q[i] <= rank_d[i];
    end
  end

  // payload registers and registered payload read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_mode_q <= mode_i;
      req_key_q <= key_i;
      req_data_q <= entry_data_i[PayloadWidth-1:0];
    end
    if (wr_en) begin
      key_mem_q[wr_idx] <= req_key_q;
      pay_q[wr_idx] <= req_data_q;
    end
    if (cmd_i.exec) begin
      if (rd_en) rdata_q <= 64'(pay_q[found_idx]);
      else rdata_q <= '0;
    end
    hit_q <= hit_d;
  end

  assign hit_o = hit_q;
  assign read_data_o = rdata_q;

`ifndef SYNTHESIS
  a_count_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Entries)) else $error("live count overflow");
  a_count_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q))) else $error("count mismatch");
  a_one_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match)) else $error("duplicate key");
`endif
endmodule

// ----- rtl/lkrc_ctrl.sv -----
// request sequencer for the keyed record cache
module lkrc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lkrc_pkg::lkrc_cmd_t cmd_o,
  input  lkrc_pkg::lkrc_sts_t sts_i
);
  import lkrc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (sts_i.need_evict) cmd_o.evict = 1'b1;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("overlapping commands");
  a_exec_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o) else $error("no response after exec");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while busy");
`endif
endmodule

// ----- rtl/lru_keyed_record_cache.sv -----
// Fully associative LRU cache of keyed records with get, put, erase and clear.
// Each transaction steps through accept, an eviction slot that removes the
// least recent entry when a put to a new key finds the store at capacity,
// execute and result, and the next request is accepted in the cycle after
// the result is taken; one request is in flight at a time. The store
// resets empty and the capacity register resets to 16; it is written
// only while no request is in flight. Capacity above the number of entries
// saturates and zero makes puts do nothing.
module lru_keyed_record_cache #(
  parameter int unsigned ENTRIES = lkrc_pkg::EntriesDefault,
  parameter int unsigned PAYLOAD_WIDTH = lkrc_pkg::PayloadWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [63:0] entry_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [63:0] read_data_o
);
  import lkrc_pkg::*;

  logic [CapWidth-1:0] cap_q;
  lkrc_cmd_t cmd;
  lkrc_sts_t sts;

  // capacity register, writable while idle
  assign cfg_ready_o = in_ready_o;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cap_q <= CapReset;
    else if (cfg_valid_i && cfg_ready_o) cap_q <= cfg_data_i;
  end

  lkrc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  lkrc_datapath #(.Entries(ENTRIES), .PayloadWidth(PAYLOAD_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cap_i(cap_q),
    .mode_i, .key_i, .entry_data_i, .hit_o, .read_data_o
  );
endmodule

// ----- verif/lkrc_checker.sv -----
// checker for the keyed record cache: lru model and result scoreboard
`timescale 1ns / 100ps
module lkrc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] key_i,
  input  logic [63:0] entry_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        hit_i,
  input  logic [63:0] read_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  import lkrc_pkg::*;

  localparam int Slots = 16;

  typedef struct packed {
    logic        hit;
    logic [63:0] data;
  } lookup_t;

  logic        slot_live [Slots];
  logic [31:0] slot_key [Slots];
  logic [63:0] slot_data [Slots];
  int          slot_age [Slots];
  int          live_n;
  logic [4:0]  cap_reg;
  lookup_t     expected_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();

  function automatic int find_slot(logic [31:0] k);
    for (int j = 0; j < Slots; j++)
      if (slot_live[j] && slot_key[j] == k) return j;
    return -1;
  endfunction

  // move slot to most recent position
  function automatic void touch(int i);
    int r;
    r = slot_age[i];
    for (int j = 0; j < Slots; j++)
      if (slot_live[j] && slot_age[j] < r) slot_age[j]++;
    slot_age[i] = 0;
  endfunction

  function automatic void drop(int i);
    int r;
    r = slot_age[i];
    slot_live[i] = 1'b0;
    slot_age[i] = 0;
    for (int j = 0; j < Slots; j++)
      if (slot_live[j] && slot_age[j] > r) slot_age[j]--;
    if (live_n > 0) live_n--;
  endfunction

  function automatic void wipe();
    for (int j = 0; j < Slots; j++) begin
      slot_live[j] = 1'b0;
      slot_age[j] = 0;
    end
    live_n = 0;
  endfunction

  function automatic lookup_t apply_request(mode_e m, logic [31:0] k, logic [63:0] d);
    lookup_t res;
    int i, victim, best, cap;
    res = '0;
    cap = (cap_reg > Slots) ? Slots : int'(cap_reg);
    case (m)
      MODE_GET: begin
        i = find_slot(k);
        if (i >= 0) begin
          res.hit = 1'b1;
          res.data = slot_data[i];
          touch(i);
        end
      end
      MODE_PUT: begin
        if (cap != 0) begin
          i = find_slot(k);
          if (i >= 0) begin
            res.hit = 1'b1;
            slot_data[i] = d;
            touch(i);
          end else begin
            // evict least recent, highest index on ties
            if (live_n >= cap) begin
              victim = -1;
              best = 0;
              for (int j = 0; j < Slots; j++)
                if (slot_live[j] && (victim < 0 || slot_age[j] >= best)) begin
                  victim = j;
                  best = slot_age[j];
                end
              if (victim >= 0) drop(victim);
            end
            i = -1;
            for (int j = Slots - 1; j >= 0; j--)
              if (!slot_live[j]) i = j;
            if (i >= 0) begin
              for (int j = 0; j < Slots; j++)
                if (slot_live[j]) slot_age[j]++;
              slot_live[i] = 1'b1;
              slot_key[i] = k;
              slot_data[i] = d;
              slot_age[i] = 0;
              live_n++;
            end
          end
        end
      end
      MODE_ERASE: begin
        i = find_slot(k);
        if (i >= 0) begin
          res.hit = 1'b1;
          drop(i);
        end
      end
      default: wipe();
    endcase
    return res;
  endfunction

  // predict on input transactions, compare on output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t exp_r;
    if (!rst_ni) begin
      wipe();
      cap_reg = CapReset;
      expected_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cap_reg = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result hit=%0b data=%h", hit_i, read_data_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.hit !== hit_i || exp_r.data !== read_data_i) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected hit=%0b data=%h, got hit=%0b data=%h",
                       exp_r.hit, exp_r.data, hit_i, read_data_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.insert(expected_q.size(),
                          apply_request(mode_e'(mode_i), key_i, entry_data_i));
    end
  end
endmodule

// ----- verif/tb_lru_keyed_record_cache.sv -----
// testbench top: stimulus, clock, reset and verdict for the record cache
`timescale 1ns / 100ps
module tb_lru_keyed_record_cache;
  import lkrc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = MODE_GET;
  logic [31:0] key_i = '0;
  logic [63:0] entry_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic [63:0] read_data_o;
  int          fail_count;
  int          pending;
  bit          hold_off = 1'b0;
  bit          random_ready = 1'b0;
  logic [31:0] key_pool [8];

  always #5 clk_i = ~clk_i;

  lru_keyed_record_cache u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .mode_i, .key_i, .entry_data_i,
    .out_valid_o, .out_ready_i, .hit_o, .read_data_o
  );

  lkrc_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .key_i, .entry_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o), .read_data_i(read_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else if (!random_ready) out_ready_i <= 1'b1;
      else if (out_ready_i && out_valid_o) begin
        gap = $urandom_range(0, 11);
        if (gap != 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end else out_ready_i <= 1'b1;
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_request(mode_e m, logic [31:0] k, logic [63:0] d, bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    key_i <= k;
    entry_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [4:0] c);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // mostly keys from a small pool so that hits, updates and evictions occur
  task automatic random_phase(int n, int pool_n);
    int r;
    mode_e m;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      m = (r < 40) ? MODE_PUT : (r < 78) ? MODE_GET : (r < 97) ? MODE_ERASE : MODE_CLEAR;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
      send_request(m, k, rand_word(), i % 50 < 35);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;

    // directed: key extremes, all modes, misses, update, clear
    send_request(MODE_GET, 32'h8000_0000, '0, 1'b0);
    send_request(MODE_ERASE, 32'h7fff_ffff, '0, 1'b0);
    send_request(MODE_PUT, 32'h8000_0000, '1, 1'b0);
    send_request(MODE_PUT, 32'h7fff_ffff, '0, 1'b0);
    send_request(MODE_PUT, 32'h0, 64'h5555_aaaa_5555_aaaa, 1'b0);
    send_request(MODE_PUT, 32'hffff_ffff, 64'haaaa_5555_aaaa_5555, 1'b0);
    send_request(MODE_GET, 32'h8000_0000, '0, 1'b0);
    send_request(MODE_PUT, 32'h7fff_ffff, 64'h1234, 1'b0);
    send_request(MODE_GET, 32'h7fff_ffff, '1, 1'b0);
    send_request(MODE_ERASE, 32'h0, '0, 1'b0);
    send_request(MODE_GET, 32'h0, '0, 1'b0);
    send_request(MODE_CLEAR, 32'hffff_ffff, '1, 1'b0);
    send_request(MODE_GET, 32'hffff_ffff, '0, 1'b0);
    // fill past capacity to force evictions
    for (int i = 0; i < 18; i++) send_request(MODE_PUT, i, rand_word(), 1'b0);

    // capacity two: eviction order
    write_capacity(5'd2);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    random_phase(60, 4);
    // capacity zero: puts ignored, others still work
    write_capacity(5'd0);
    random_phase(30, 4);
    write_capacity(5'd31);
    random_phase(150, 8);
    // lowered below live count
    write_capacity(5'd5);
    random_phase(100, 8);
    write_capacity(5'd16);
    random_ready = 1'b1;
    random_phase(150, 8);

    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(20, 8);
    join
    drain();
    random_phase(90, 8);

    drain();
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
